// ----- sv/trs_pkg.sv -----
package trs_pkg;

  localparam int SizeBits    = 15;
  localparam int StepBits    = 4;
  localparam int BlkBits     = 5;
  localparam int CfgAddrBits = 3;
  localparam int CfgDataBits = 15;
  localparam int ProdBits    = 2 * SizeBits;

  localparam logic [SizeBits-1:0] SizeMax = {SizeBits{1'b1}};

  // front register, product register, four dividers in sequence, output register
  localparam int Latency = 2 + ProdBits + 3 * SizeBits + 1;

  typedef enum logic [CfgAddrBits-1:0] {
    RegDownscaleSteps = 3'd0,
    RegMinResolution  = 3'd1,
    RegMaxResolution  = 3'd2,
    RegVolumeMode     = 3'd3,
    RegAlignEnable    = 3'd4,
    RegBlockWidth     = 3'd5,
    RegBlockHeight    = 3'd6
  } trs_reg_e;

  typedef struct packed {
    logic [SizeBits-1:0] src_width;
    logic [SizeBits-1:0] src_height;
  } trs_req_t;

  typedef struct packed {
    logic [SizeBits-1:0] target_width;
    logic [SizeBits-1:0] target_height;
    logic                adjusted;
    logic                div_error;
  } trs_res_t;

  typedef struct packed {
    logic [StepBits-1:0] downscale_steps;
    logic [SizeBits-1:0] min_resolution;
    logic [SizeBits-1:0] max_resolution;
    logic                volume_mode;
    logic                align_enable;
    logic [BlkBits-1:0]  block_width;
    logic [BlkBits-1:0]  block_height;
  } trs_cfg_t;

  typedef struct packed {
    logic [SizeBits-1:0] sx;
    logic [SizeBits-1:0] sy;
    logic [SizeBits-1:0] tx;
    logic [SizeBits-1:0] ty;
    logic                gt;
    logic                lt;
  } trs_aspect_t;

  typedef struct packed {
    logic [SizeBits-1:0] sx;
    logic [SizeBits-1:0] tx;
    logic [SizeBits-1:0] ty;
  } trs_scale_t;

  typedef struct packed {
    logic [SizeBits-1:0] tx;
    logic [SizeBits-1:0] ty;
    logic                use_div;
    logic                err;
  } trs_vol_t;

  typedef struct packed {
    logic [SizeBits-1:0] tx;
    logic                err;
  } trs_alw_t;

  function automatic logic [SizeBits-1:0] clamp_side(logic [SizeBits-1:0] v,
                                                      logic [SizeBits-1:0] lo,
                                                      logic [SizeBits-1:0] hi);
    logic [SizeBits-1:0] r;
    r = (v < lo) ? lo : v;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

  function automatic logic [SizeBits-1:0] round_up(logic [SizeBits-1:0] v,
                                                    logic [BlkBits-1:0] blk,
                                                    logic [BlkBits-1:0] rem);
    logic [SizeBits:0] sum;
    sum = {1'b0, v} + {{(SizeBits+1-BlkBits){1'b0}}, blk}
        - {{(SizeBits+1-BlkBits){1'b0}}, rem};
    return sum[SizeBits] ? SizeMax : sum[SizeBits-1:0];
  endfunction

endpackage

// ----- sv/trs_div.sv -----
module trs_div import trs_pkg::*; #(
  parameter int NUM_W  = SizeBits,
  parameter int DEN_W  = SizeBits,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quot_o,
  output logic [DEN_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]    vld_q;
  logic [NUM_W-1:0]  num_q  [NUM_W+1];
  logic [NUM_W-1:0]  quot_q [NUM_W+1];
  logic [DEN_W-1:0]  rem_q  [NUM_W+1];
  logic [DEN_W-1:0]  den_q  [NUM_W+1];
  logic [SIDE_W-1:0] side_q [NUM_W+1];

  assign vld_q[0]  = valid_i;
  assign num_q[0]  = num_i;
  assign quot_q[0] = '0;
  assign rem_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_d;

    assign trial = {rem_q[k], num_q[k][NUM_W-1]};
    assign diff  = trial - {1'b0, den_q[k]};
    assign ge    = trial >= {1'b0, den_q[k]};
    assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k+1]  <= {num_q[k][NUM_W-2:0], 1'b0};
      quot_q[k+1] <= {quot_q[k][NUM_W-2:0], ge};
      rem_q[k+1]  <= rem_d;
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[NUM_W];
  assign quot_o  = quot_q[NUM_W];
  assign rem_o   = rem_q[NUM_W];
  assign side_o  = side_q[NUM_W];

endmodule

// ----- sv/trs_cfg.sv -----
module trs_cfg import trs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,
  output trs_cfg_t               cfg_o
);

  trs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (trs_reg_e'(cfg_addr_i))
        RegDownscaleSteps: cfg_d.downscale_steps = cfg_data_i[StepBits-1:0];
        RegMinResolution:  cfg_d.min_resolution  = cfg_data_i[SizeBits-1:0];
        RegMaxResolution:  cfg_d.max_resolution  = cfg_data_i[SizeBits-1:0];
        RegVolumeMode:     cfg_d.volume_mode     = cfg_data_i[0];
        RegAlignEnable:    cfg_d.align_enable    = cfg_data_i[0];
        RegBlockWidth:     cfg_d.block_width     = cfg_data_i[BlkBits-1:0];
        RegBlockHeight:    cfg_d.block_height    = cfg_data_i[BlkBits-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.downscale_steps <= '0;
      cfg_q.min_resolution  <= SizeBits'(1);
      cfg_q.max_resolution  <= SizeBits'(16384);
      cfg_q.volume_mode     <= 1'b0;
      cfg_q.align_enable    <= 1'b0;
      cfg_q.block_width     <= BlkBits'(4);
      cfg_q.block_height    <= BlkBits'(4);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/texture_target_resolution.sv -----
// Texture target resolution: one size pair enters per cycle while busy_o is low
// (it always is), and its result appears on res_o with res_valid_o high for one
// cycle, once past the front and product registers, four bit-serial pipelined
// dividers in sequence and the output register: the aspect rescale (30 stages),
// the volume scale factor and width and the block remainders (15 stages each).
// The receiver cannot stall; results must be taken as they appear. Configuration
// writes are always ready and must only be made while no item is in flight.
module texture_target_resolution import trs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  trs_req_t               req_i,
  output logic                   res_valid_o,
  output trs_res_t               res_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  trs_cfg_t cfg;

  trs_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_addr_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // shift and clamp
  logic                v1_q;
  logic [SizeBits-1:0] sx1_q, sy1_q, tx1_q, ty1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    sx1_q <= req_i.src_width;
    sy1_q <= req_i.src_height;
    tx1_q <= clamp_side(req_i.src_width >> cfg.downscale_steps,
                        cfg.min_resolution, cfg.max_resolution);
    ty1_q <= clamp_side(req_i.src_height >> cfg.downscale_steps,
                        cfg.min_resolution, cfg.max_resolution);
  end

  // aspect product
  logic                v2_q;
  logic [ProdBits-1:0] num2_q;
  logic [SizeBits-1:0] den2_q;
  trs_aspect_t         side2_q;
  logic                gt1;

  assign gt1 = sx1_q > sy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num2_q     <= gt1 ? ProdBits'(tx1_q) * ProdBits'(sy1_q)
                      : ProdBits'(ty1_q) * ProdBits'(sx1_q);
    den2_q     <= gt1 ? sx1_q : sy1_q;
    side2_q.sx <= sx1_q;
    side2_q.sy <= sy1_q;
    side2_q.tx <= tx1_q;
    side2_q.ty <= ty1_q;
    side2_q.gt <= gt1;
    side2_q.lt <= sx1_q < sy1_q;
  end

  logic                va;
  logic [ProdBits-1:0] qa;
  trs_aspect_t         sa;
  trs_scale_t          sb_in;

  trs_div #(.NUM_W(ProdBits), .DEN_W(SizeBits), .SIDE_W($bits(trs_aspect_t))) u_div_aspect (
    .clk_i,
    .rst_ni,
    .valid_i (v2_q),
    .num_i   (num2_q),
    .den_i   (den2_q),
    .side_i  (side2_q),
    .valid_o (va),
    .quot_o  (qa),
    .rem_o   (),
    .side_o  (sa)
  );

  assign sb_in.sx = sa.sx;
  assign sb_in.tx = sa.lt ? qa[SizeBits-1:0] : sa.tx;
  assign sb_in.ty = sa.gt ? qa[SizeBits-1:0] : sa.ty;

  logic                vb;
  logic [SizeBits-1:0] qb;
  trs_scale_t          sb;
  trs_vol_t            sc_in;

  trs_div #(.NUM_W(SizeBits), .DEN_W(SizeBits), .SIDE_W($bits(trs_scale_t))) u_div_scale (
    .clk_i,
    .rst_ni,
    .valid_i (va),
    .num_i   (sa.sy),
    .den_i   (sb_in.ty),
    .side_i  (sb_in),
    .valid_o (vb),
    .quot_o  (qb),
    .rem_o   (),
    .side_o  (sb)
  );

  assign sc_in.tx      = sb.tx;
  assign sc_in.ty      = sb.ty;
  assign sc_in.err     = cfg.volume_mode && ((sb.ty == '0) || (qb == '0));
  assign sc_in.use_div = cfg.volume_mode && (sb.ty != '0) && (qb != '0);

  logic                vc;
  logic [SizeBits-1:0] qc;
  trs_vol_t            sc;
  trs_alw_t            sd_in;

  trs_div #(.NUM_W(SizeBits), .DEN_W(SizeBits), .SIDE_W($bits(trs_vol_t))) u_div_volume (
    .clk_i,
    .rst_ni,
    .valid_i (vb),
    .num_i   (sb.sx),
    .den_i   (qb),
    .side_i  (sc_in),
    .valid_o (vc),
    .quot_o  (qc),
    .rem_o   (),
    .side_o  (sc)
  );

  assign sd_in.tx  = sc.use_div ? qc : sc.tx;
  assign sd_in.err = sc.err;

  logic               vd, ve;
  logic [BlkBits-1:0] rd, re;
  trs_alw_t           sd;
  logic [SizeBits-1:0] se;

  trs_div #(.NUM_W(SizeBits), .DEN_W(BlkBits), .SIDE_W($bits(trs_alw_t))) u_div_align_w (
    .clk_i,
    .rst_ni,
    .valid_i (vc),
    .num_i   (sd_in.tx),
    .den_i   (cfg.block_width),
    .side_i  (sd_in),
    .valid_o (vd),
    .quot_o  (),
    .rem_o   (rd),
    .side_o  (sd)
  );

  trs_div #(.NUM_W(SizeBits), .DEN_W(BlkBits), .SIDE_W(SizeBits)) u_div_align_h (
    .clk_i,
    .rst_ni,
    .valid_i (vc),
    .num_i   (sc.ty),
    .den_i   (cfg.block_height),
    .side_i  (sc.ty),
    .valid_o (ve),
    .quot_o  (),
    .rem_o   (re),
    .side_o  (se)
  );

  // round up to block size when alignment is enabled
  logic     res_valid_q;
  trs_res_t res_q, res_d;
  logic     bw_zero, bh_zero, w_odd, h_odd;

  assign bw_zero = cfg.block_width == '0;
  assign bh_zero = cfg.block_height == '0;
  assign w_odd   = !bw_zero && (rd != '0);
  assign h_odd   = !bh_zero && (re != '0);

  always_comb begin
    res_d.target_width  = sd.tx;
    res_d.target_height = se;
    res_d.adjusted      = 1'b0;
    res_d.div_error     = sd.err;
    if (cfg.align_enable) begin
      if (w_odd) begin
        res_d.target_width = round_up(sd.tx, cfg.block_width, rd);
      end
      if (h_odd) begin
        res_d.target_height = round_up(se, cfg.block_height, re);
      end
      res_d.adjusted  = w_odd || h_odd;
      res_d.div_error = sd.err || bw_zero || bh_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= vd && ve;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/trs_checker.sv -----
module trs_checker import trs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     res_valid_o,
  input trs_res_t res_o,
  input logic     cfg_ready_o
);

  a_no_busy : assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_result_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without item");

  a_item_has_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency res_valid_o)
    else $error("item lost");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.adjusted) |-> cfg_ready_o)
    else $error("config port blocked");

endmodule

bind texture_target_resolution trs_checker u_trs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o),
  .res_o       (res_o),
  .cfg_ready_o (cfg_ready_o)
);
